// ===== design/pg3_pkg.sv =====
// Package for the pseudo-G3 power state controller.
// Holds the state, request and register codes and the item/result structs.
// No dependencies.
`default_nettype none

package pg3_pkg;

    // Default width of the DC countdown register.
    localparam int COUNT_BITS_DEF = 16;

    // Width of the 16-bit count field on the input stream.
    localparam int CNT_FIELD_W = 16;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef enum logic [2:0] {
        ST_DISABLED   = 3'd0,
        ST_IDLE       = 3'd1,
        ST_WAIT_ENTRY = 3'd2,
        ST_ENTERED    = 3'd3,
        ST_WAKE_WAIT  = 3'd4
    } t_pg3_fsm;

    typedef enum logic [1:0] {
        REQ_POLL    = 2'd0,
        REQ_PROGRAM = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_pg3_req;

    // System sleep state codes; values above G3 are "other".
    localparam logic [2:0] SYS_S0 = 3'd0;
    localparam logic [2:0] SYS_S3 = 3'd1;
    localparam logic [2:0] SYS_S4 = 3'd2;
    localparam logic [2:0] SYS_S5 = 3'd3;
    localparam logic [2:0] SYS_G3 = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_IDX_ENABLE = 1'b0;
    localparam logic CFG_IDX_WAKE   = 1'b1;

    typedef struct packed {
        logic [1:0]             req_type;
        logic                   counter_is_dc;
        logic [CNT_FIELD_W-1:0] count_seconds;
        logic [2:0]             system_state;
        logic                   ac_ok;
        logic                   ac_read_error;
        logic                   virtual_battery;
        logic                   espi_reset_high;
        logic                   sus_ack;
        logic                   rsmrst_high;
    } t_pg3_item;

    typedef struct packed {
        logic       exit_flag_set;
        logic       entered_flag_set;
        logic       wake_request;
        logic       exit_pulse;
        logic       enter_pulse;
        logic       prev_in_pg3;
        logic       in_pg3;
        logic [2:0] pwr_state;
    } t_pg3_result;

    typedef struct packed {
        logic pg3_enable;
        logic wake_after_exit;
    } t_pg3_cfg;

endpackage

`default_nettype wire

// ===== design/pg3_in_stage.sv =====
// Input register of the pseudo-G3 controller: captures one stream transaction.
// Depends on pg3_pkg.
`default_nettype none

module pg3_in_stage (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [pg3_pkg::S_TDATA_W-1:0]   i_tdata,  // dc 0, count 16:1, sys 19:17,
                                                      // ac_ok 20, ac_err 21, vbat 22,
                                                      // espi 23, ack 24, rsmrst 25
    input  wire  [pg3_pkg::S_TUSER_W-1:0]   i_tuser,  // req_type 1:0
    input  wire                             i_take,   // core consumes the held item
    output logic                            o_valid,
    output pg3_pkg::t_pg3_item              o_item
);

    logic               r_valid;
    pg3_pkg::t_pg3_item r_item;
    pg3_pkg::t_pg3_item w_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        w_item.req_type        = i_tuser[1:0];
        w_item.counter_is_dc   = i_tdata[0];
        w_item.count_seconds   = i_tdata[16:1];
        w_item.system_state    = i_tdata[19:17];
        w_item.ac_ok           = i_tdata[20];
        w_item.ac_read_error   = i_tdata[21];
        w_item.virtual_battery = i_tdata[22];
        w_item.espi_reset_high = i_tdata[23];
        w_item.sus_ack         = i_tdata[24];
        w_item.rsmrst_high     = i_tdata[25];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= w_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/pg3_core.sv =====
// State machine and DC countdown of the pseudo-G3 controller.
// Depends on pg3_pkg.
`default_nettype none

module pg3_core #(
    parameter int COUNT_BITS = pg3_pkg::COUNT_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  pg3_pkg::t_pg3_item   i_item,
    input  pg3_pkg::t_pg3_cfg    i_cfg,
    output pg3_pkg::t_pg3_result o_result
);

    localparam int CW = (COUNT_BITS > pg3_pkg::CNT_FIELD_W) ? COUNT_BITS
                                                             : pg3_pkg::CNT_FIELD_W;
    localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});

    pg3_pkg::t_pg3_fsm      r_cur_state, n_cur_state;
    pg3_pkg::t_pg3_fsm      r_last_state, n_last_state;
    logic [COUNT_BITS-1:0]  r_dc_remaining, n_dc_remaining;
    logic                   r_dc_running, n_dc_running;
    logic                   r_wake_pending, n_wake_pending;

    logic            w_poll, w_prog, w_tick;
    logic            w_ac_present, w_sleep45, w_awake, w_entry_ok;
    logic            w_expire, w_wake_on_expire;
    logic [CW-1:0]   w_cnt_ext, w_cnt_clamp;

    assign w_poll = (i_item.req_type == pg3_pkg::REQ_POLL);
    assign w_prog = (i_item.req_type == pg3_pkg::REQ_PROGRAM);
    assign w_tick = (i_item.req_type == pg3_pkg::REQ_TICK);

    assign w_ac_present = i_item.ac_ok && !i_item.ac_read_error;
    assign w_sleep45    = (i_item.system_state == pg3_pkg::SYS_S4) ||
                          (i_item.system_state == pg3_pkg::SYS_S5);
    assign w_awake      = (i_item.system_state == pg3_pkg::SYS_S0) ||
                          (i_item.system_state == pg3_pkg::SYS_S3) ||
                          (i_item.system_state == pg3_pkg::SYS_G3);
    assign w_entry_ok   = !i_item.ac_read_error &&
                          !(w_ac_present && !i_item.virtual_battery) &&
                          !(i_item.espi_reset_high && !i_item.sus_ack);

    // Clamp the count into the countdown range
    assign w_cnt_ext   = CW'(i_item.count_seconds);
    assign w_cnt_clamp = (w_cnt_ext > CNT_MAX) ? CNT_MAX : w_cnt_ext;

    // Expiry: programmed zero, or tick reaching zero
    always_comb begin
        w_expire = 1'b0;
        if (w_prog && (r_cur_state != pg3_pkg::ST_DISABLED) && i_item.counter_is_dc) begin
            w_expire = (w_cnt_clamp == '0);
        end else if (w_tick && r_dc_running) begin
            w_expire = (r_dc_remaining <= COUNT_BITS'(1));
        end
    end

    assign w_wake_on_expire = !i_item.ac_read_error &&
                              !(w_ac_present && !i_item.virtual_battery);

    // Next state
    always_comb begin
        n_cur_state = r_cur_state;
        if (w_poll) begin
            unique case (r_cur_state)
                pg3_pkg::ST_DISABLED: begin
                    if (i_cfg.pg3_enable) n_cur_state = pg3_pkg::ST_IDLE;
                end
                pg3_pkg::ST_IDLE: begin
                    if (!i_cfg.pg3_enable)  n_cur_state = pg3_pkg::ST_DISABLED;
                    else if (w_sleep45)     n_cur_state = pg3_pkg::ST_WAIT_ENTRY;
                end
                pg3_pkg::ST_WAIT_ENTRY: begin
                    if (w_awake)                      n_cur_state = pg3_pkg::ST_IDLE;
                    else if (w_sleep45 && w_entry_ok) n_cur_state = pg3_pkg::ST_ENTERED;
                end
                pg3_pkg::ST_ENTERED: begin
                    if (w_awake) begin
                        n_cur_state = pg3_pkg::ST_IDLE;
                    end else if (w_sleep45) begin
                        if (w_ac_present && !i_item.virtual_battery)
                            n_cur_state = pg3_pkg::ST_WAIT_ENTRY;
                        else if (i_item.rsmrst_high)
                            n_cur_state = pg3_pkg::ST_WAKE_WAIT;
                    end
                end
                pg3_pkg::ST_WAKE_WAIT: begin
                    if (w_awake) n_cur_state = pg3_pkg::ST_IDLE;
                end
                default: n_cur_state = pg3_pkg::ST_DISABLED;
            endcase
        end
        // every move goes to a different state
        n_last_state = (n_cur_state != r_cur_state) ? r_cur_state : r_last_state;
    end

    // Countdown and wake pending
    always_comb begin
        n_dc_remaining = r_dc_remaining;
        n_dc_running   = r_dc_running;
        n_wake_pending = r_wake_pending;
        if (w_poll) begin
            n_wake_pending = 1'b0;
        end else if (w_expire) begin
            n_dc_running   = 1'b0;
            n_dc_remaining = '0;
            if (w_wake_on_expire) n_wake_pending = 1'b1;
        end else if (w_prog && (r_cur_state != pg3_pkg::ST_DISABLED) &&
                     i_item.counter_is_dc) begin
            n_dc_remaining = w_cnt_clamp[COUNT_BITS-1:0];
            n_dc_running   = 1'b1;
        end else if (w_tick && r_dc_running) begin
            n_dc_remaining = r_dc_remaining - COUNT_BITS'(1);
        end
    end

    // Result outputs
    always_comb begin
        o_result.pwr_state        = n_cur_state;
        o_result.in_pg3           = (n_cur_state == pg3_pkg::ST_ENTERED);
        o_result.prev_in_pg3      = (n_last_state == pg3_pkg::ST_ENTERED);
        o_result.enter_pulse      = w_poll && (r_cur_state == pg3_pkg::ST_WAIT_ENTRY) &&
                                    (n_cur_state == pg3_pkg::ST_ENTERED);
        o_result.exit_pulse       = w_poll && r_wake_pending;
        o_result.wake_request     = w_poll && r_wake_pending && i_cfg.wake_after_exit;
        o_result.entered_flag_set = w_poll && (r_cur_state == pg3_pkg::ST_ENTERED);
        o_result.exit_flag_set    = w_poll && (r_cur_state == pg3_pkg::ST_WAKE_WAIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state    <= pg3_pkg::ST_DISABLED;
            r_last_state   <= pg3_pkg::ST_DISABLED;
            r_dc_remaining <= '0;
            r_dc_running   <= 1'b0;
            r_wake_pending <= 1'b0;
        end else if (i_fire) begin
            r_cur_state    <= n_cur_state;
            r_last_state   <= n_last_state;
            r_dc_remaining <= n_dc_remaining;
            r_dc_running   <= n_dc_running;
            r_wake_pending <= n_wake_pending;
        end
    end

endmodule

`default_nettype wire

// ===== design/pg3_out_stage.sv =====
// Result register of the pseudo-G3 controller, driving the master stream.
// Depends on pg3_pkg.
`default_nettype none

module pg3_out_stage (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_load,
    input  pg3_pkg::t_pg3_result           i_result,
    output logic                           o_can_load,
    output logic                           o_tvalid,
    input  wire                            i_tready,
    output logic [pg3_pkg::M_TDATA_W-1:0]  o_tdata
);

    logic                 r_valid;
    pg3_pkg::t_pg3_result r_result;

    assign o_can_load = !r_valid || i_tready;
    assign o_tvalid   = r_valid;
    assign o_tdata    = {(pg3_pkg::M_TDATA_W - $bits(pg3_pkg::t_pg3_result))'(0), r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== design/pseudo_g3_power_state_controller.sv =====
// Pseudo-G3 power state controller, top level.
// Path: a transaction accepted into the input register moves into the result register
// when the result slot is free, then leaves from there (input register, then result register).
// Throughput: one item per cycle; a held result stalls the input once both registers fill.
// Reset (i_rst_n low, synchronous): state disabled, countdown stopped, config and the
// valid flags of both registers cleared, pipeline emptied. Depends on pg3_pkg and the pg3_* modules.
`default_nettype none

module pseudo_g3_power_state_controller #(
    parameter int COUNT_BITS = pg3_pkg::COUNT_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input stream
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [pg3_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // counter_is_dc 0, count_seconds 16:1,
                                                          // system_state 19:17, ac_ok 20,
                                                          // ac_read_error 21, virtual_battery 22,
                                                          // espi_reset_high 23, sus_ack 24,
                                                          // rsmrst_high 25, zero 31:26
    input  wire  [pg3_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // req_type 1:0
    // result stream
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [pg3_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // pwr_state 2:0, in_pg3 3,
                                                          // prev_in_pg3 4, enter_pulse 5,
                                                          // exit_pulse 6, wake_request 7,
                                                          // entered_flag_set 8,
                                                          // exit_flag_set 9, zero 15:10
    // configuration writes
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire                            i_cfg_index,
    input  wire                            i_cfg_data
);

    logic                 w_in_valid;
    pg3_pkg::t_pg3_item   w_item;
    pg3_pkg::t_pg3_result w_result;
    logic                 w_can_load;
    logic                 w_fire;
    pg3_pkg::t_pg3_cfg    r_cfg;

    // An item moves from the input register into the result register when
    // the result slot is empty or being drained in the same cycle.
    assign w_fire = w_in_valid && w_can_load;

    // Config is taken every cycle; the host must write only while the block is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pg3_pkg::CFG_IDX_ENABLE: r_cfg.pg3_enable      <= i_cfg_data;
                pg3_pkg::CFG_IDX_WAKE:   r_cfg.wake_after_exit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pg3_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    pg3_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    pg3_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

    // in_pg3 must agree with the reported state
    a_in_pg3_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[2:0] == pg3_pkg::ST_ENTERED)))
        else $error("in_pg3 disagrees with pwr_state");

    // entry pulse only on the move into the entered state
    a_enter_lands_entered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[2:0] == pg3_pkg::ST_ENTERED))
        else $error("enter pulse without entered state");

    // wake request rides only with an exit pulse
    a_wake_needs_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7]) |-> m_axis_tdata[6])
        else $error("wake request without exit pulse");

    // a transaction into the core always lands in the result register next edge
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> m_axis_tvalid)
        else $error("fired item missing from result stage");

endmodule

`default_nettype wire
